>>> rtl/ahw_pkg.sv
// ahw_pkg: types and constants shared by the hang watchdog files
// depends on nothing; imported by ahw_req_if, ahw_core and ap_hang_watchdog_top
package ahw_pkg;

   localparam int TICKS_PER_SEC_DEF = 1000;
   localparam int KIND_W            = 3;
   localparam int CMD_W             = 3;
   localparam int FIELD_W           = 16;
   // a timeout of up to 65535 s at up to 1000 ticks per second fits in 26 bits
   localparam int TICK_W            = 26;

   localparam logic [FIELD_W-1:0] FLAG_START_ON_RESUME = 16'h0001;
   localparam logic [FIELD_W-1:0] FLAG_STOP_ON_SUSPEND = 16'h0002;
   localparam logic [FIELD_W-1:0] FLAG_KNOWN_MASK =
      FLAG_START_ON_RESUME | FLAG_STOP_ON_SUSPEND;

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK     = 3'd0,
      KIND_HOST_CMD = 3'd1,
      KIND_RESUME   = 3'd2,
      KIND_SUSPEND  = 3'd3,
      KIND_SHUTDOWN = 3'd4
   } kind_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_RELOAD       = 3'd0,
      CMD_CANCEL       = 3'd1,
      CMD_SET_PARAMS   = 3'd2,
      CMD_GET_STATUS   = 3'd3,
      CMD_CLEAR_STATUS = 3'd4
   } cmd_type;

   typedef enum logic {
      RESULT_SUCCESS = 1'b0,
      RESULT_INVALID = 1'b1
   } result_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [CMD_W-1:0]   command;
      logic [FIELD_W-1:0] cmd_flags;
      logic [FIELD_W-1:0] cmd_timeout_sec;
      logic               last_reset_was_hang;
   } req_type;

   typedef struct packed {
      logic cmd_result;
      logic ap_boot_status;
      logic hang_reset;
      logic timer_running;
   } rsp_type;

endpackage

>>> rtl/ahw_if.sv
// ahw_req_if and ahw_rsp_if: valid/ready channels of the hang watchdog
// depends on ahw_pkg for field widths
interface ahw_req_if
   import ahw_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [CMD_W-1:0]   command;
   logic [FIELD_W-1:0] cmd_flags;
   logic [FIELD_W-1:0] cmd_timeout_sec;
   logic               last_reset_was_hang;

   modport source (
      output valid, kind, command, cmd_flags, cmd_timeout_sec, last_reset_was_hang,
      input  ready
   );
   modport sink (
      input  valid, kind, command, cmd_flags, cmd_timeout_sec, last_reset_was_hang,
      output ready
   );
endinterface

interface ahw_rsp_if;
   logic valid;
   logic ready;
   logic cmd_result;
   logic ap_boot_status;
   logic hang_reset;
   logic timer_running;

   modport source (
      output valid, cmd_result, ap_boot_status, hang_reset, timer_running,
      input  ready
   );
   modport sink (
      input  valid, cmd_result, ap_boot_status, hang_reset, timer_running,
      output ready
   );
endinterface

>>> rtl/ahw_core.sv
// ahw_core: watchdog state (countdown, parameters, boot mark) and per-request decode
// depends on ahw_pkg; instantiated by ap_hang_watchdog_top
module ahw_core
   import ahw_pkg::*;
#(
   parameter int TICKS_PER_SEC = TICKS_PER_SEC_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    step_valid,
   input  req_type step_req,
   output rsp_type step_rsp
);

   logic [TICK_W-1:0] remaining_ff, remaining_in;
   logic [TICK_W-1:0] load_ff, load_in;
   logic              armed_ff, armed_in;
   logic              start_on_resume_ff, start_on_resume_in;
   logic              stop_on_suspend_ff, stop_on_suspend_in;
   logic              boot_mark_ff, boot_mark_in;
   logic [TICK_W-1:0] load_prod;
   logic              bad_args;

   // reload value is kept as ticks so arming is a plain copy
   assign load_prod = TICK_W'(step_req.cmd_timeout_sec) * TICK_W'(TICKS_PER_SEC);
   assign bad_args  = (step_req.cmd_flags != '0) || (step_req.cmd_timeout_sec != '0);

   always_comb begin
      remaining_in       = remaining_ff;
      load_in            = load_ff;
      armed_in           = armed_ff;
      start_on_resume_in = start_on_resume_ff;
      stop_on_suspend_in = stop_on_suspend_ff;
      boot_mark_in       = boot_mark_ff;
      step_rsp           = '0;

      case (step_req.kind)
         KIND_TICK: begin
            if (armed_ff) begin
               if (remaining_ff <= TICK_W'(1)) begin
                  remaining_in        = '0;
                  armed_in            = 1'b0;
                  boot_mark_in        = 1'b1;
                  step_rsp.hang_reset = 1'b1;
               end else begin
                  remaining_in = remaining_ff - TICK_W'(1);
               end
            end
         end
         KIND_HOST_CMD: begin
            if (step_req.command != CMD_SET_PARAMS && bad_args) begin
               step_rsp.cmd_result = RESULT_INVALID;
            end else begin
               case (step_req.command)
                  CMD_RELOAD: begin
                     remaining_in = load_ff;
                     armed_in     = 1'b1;
                  end
                  CMD_CANCEL: begin
                     remaining_in = '0;
                     armed_in     = 1'b0;
                  end
                  CMD_SET_PARAMS: begin
                     if ((step_req.cmd_flags & ~FLAG_KNOWN_MASK) != '0) begin
                        step_rsp.cmd_result = RESULT_INVALID;
                     end else begin
                        start_on_resume_in = (step_req.cmd_flags & FLAG_START_ON_RESUME) != '0;
                        stop_on_suspend_in = (step_req.cmd_flags & FLAG_STOP_ON_SUSPEND) != '0;
                        load_in            = load_prod;
                     end
                  end
                  CMD_GET_STATUS: begin
                     step_rsp.ap_boot_status = step_req.last_reset_was_hang & boot_mark_ff;
                  end
                  CMD_CLEAR_STATUS: begin
                     boot_mark_in = 1'b0;
                  end
                  default: begin
                     step_rsp.cmd_result = RESULT_INVALID;
                  end
               endcase
            end
         end
         KIND_RESUME: begin
            if (start_on_resume_ff) begin
               remaining_in = load_ff;
               armed_in     = 1'b1;
            end
         end
         KIND_SUSPEND: begin
            if (stop_on_suspend_ff) begin
               remaining_in = '0;
               armed_in     = 1'b0;
            end
         end
         KIND_SHUTDOWN: begin
            remaining_in       = '0;
            armed_in           = 1'b0;
            start_on_resume_in = 1'b0;
            stop_on_suspend_in = 1'b0;
            load_in            = '0;
         end
         default: begin
         end
      endcase

      step_rsp.timer_running = armed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff       <= '0;
         load_ff            <= '0;
         armed_ff           <= 1'b0;
         start_on_resume_ff <= 1'b0;
         stop_on_suspend_ff <= 1'b0;
         boot_mark_ff       <= 1'b0;
      end else if (step_valid) begin
         remaining_ff       <= remaining_in;
         load_ff            <= load_in;
         armed_ff           <= armed_in;
         start_on_resume_ff <= start_on_resume_in;
         stop_on_suspend_ff <= stop_on_suspend_in;
         boot_mark_ff       <= boot_mark_in;
      end
   end

`ifndef ASSERT_OFF
   a_idle_count_zero: assert property (@(posedge clock) disable iff (reset)
      !armed_ff |-> remaining_ff == '0)
      else $error("countdown holds a count while disarmed");

   a_expiry_marks_boot: assert property (@(posedge clock) disable iff (reset)
      (step_valid && step_rsp.hang_reset) |=> (!armed_ff && boot_mark_ff))
      else $error("expiry did not disarm and set the boot mark");

   a_shutdown_clears: assert property (@(posedge clock) disable iff (reset)
      (step_valid && step_req.kind == KIND_SHUTDOWN)
      |=> (!armed_ff && load_ff == '0 && !start_on_resume_ff && !stop_on_suspend_ff))
      else $error("shutdown left parameters or countdown behind");

   a_hang_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      step_rsp.hang_reset |-> (armed_ff && step_req.kind == KIND_TICK))
      else $error("hang reset raised outside an armed tick");
`endif

endmodule

>>> rtl/ap_hang_watchdog_top.sv
// ap_hang_watchdog_top: host hang watchdog with request and response channels
// depends on ahw_pkg, ahw_req_if, ahw_rsp_if and ahw_core
//
// Takes one request (tick, host command, resume, suspend or shutdown) per clock and
// returns exactly one response per request, in the cycle after acceptance, from an
// output register; a new request is taken whenever that register is empty or being
// drained in the same cycle, so the sustained rate is one request per clock. The
// state update is a single pass of decode plus a 26-bit decrement; the reload value
// (timeout times TICKS_PER_SEC) is multiplied once when the parameters are set and
// kept as ticks. No clearing pass after reset: the block is ready once reset falls.
module ap_hang_watchdog_top
   import ahw_pkg::*;
#(
   parameter int TICKS_PER_SEC = TICKS_PER_SEC_DEF
) (
   input  logic      clock,
   input  logic      reset,
   ahw_req_if.sink   req,
   ahw_rsp_if.source rsp
);

   req_type step_req;
   rsp_type step_rsp;
   rsp_type rsp_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    req_accept;

   assign req.ready  = !rsp_valid_ff || rsp.ready;
   assign req_accept = req.valid && req.ready;

   assign step_req.kind                = req.kind;
   assign step_req.command             = req.command;
   assign step_req.cmd_flags           = req.cmd_flags;
   assign step_req.cmd_timeout_sec     = req.cmd_timeout_sec;
   assign step_req.last_reset_was_hang = req.last_reset_was_hang;

   ahw_core #(
      .TICKS_PER_SEC (TICKS_PER_SEC)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step_valid (req_accept),
      .step_req   (step_req),
      .step_rsp   (step_rsp)
   );

   assign rsp_valid_in = req_accept || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= step_rsp;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.cmd_result     = rsp_data_ff.cmd_result;
   assign rsp.ap_boot_status = rsp_data_ff.ap_boot_status;
   assign rsp.hang_reset     = rsp_data_ff.hang_reset;
   assign rsp.timer_running  = rsp_data_ff.timer_running;

`ifndef ASSERT_OFF
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |-> !req_accept)
      else $error("request accepted while a response is stalled");

   a_response_follows: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   a_response_matches: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_data_ff == $past(step_rsp))
      else $error("response register does not hold the decoded result");
`endif

endmodule
